FILE: hw/rtl/deg_pkg.sv
package deg_pkg;

    // quotient bits of a ramp value; one divider cell per bit
    localparam int QW = 16;
    localparam int LEVEL_W = 16;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'd32768;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ATT_LVL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SUS_LVL = 3'd6;

    // how the quotient is folded into the gain at the end of the chain
    typedef struct packed {
        logic [LEVEL_W-1:0] base;
        logic               sub;
        logic               past;
    } deg_ctl_t;

    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
        clamp_level = (v > LEVEL_ONE) ? LEVEL_ONE : v;
    endfunction

endpackage

FILE: hw/rtl/deg_div_cell.sv
module deg_div_cell import deg_pkg::*; #(
    parameter int LENGTH_WIDTH = 20,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  deg_ctl_t                       in_ctl,
    input  logic [LENGTH_WIDTH-1:0]        in_rem,
    input  logic [QW-1:0]                  in_low,
    input  logic [QW-1:0]                  in_q,
    input  logic [LENGTH_WIDTH-1:0]        in_len,
    input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
    output logic                           out_valid,
    output deg_ctl_t                       out_ctl,
    output logic [LENGTH_WIDTH-1:0]        out_rem,
    output logic [QW-1:0]                  out_low,
    output logic [QW-1:0]                  out_q,
    output logic [LENGTH_WIDTH-1:0]        out_len,
    output logic signed [SAMPLE_WIDTH-1:0] out_sample
);

    logic [LENGTH_WIDTH:0]   trial;
    logic                    fits;
    logic [LENGTH_WIDTH-1:0] rem_next;
    logic                    valid_reg;

    // one restoring step: shift in the next numerator bit, try the divisor
    assign trial    = {in_rem, in_low[QW-1]};
    assign fits     = trial >= {1'b0, in_len};
    assign rem_next = fits ? LENGTH_WIDTH'(trial - {1'b0, in_len})
                           : trial[LENGTH_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_ctl    <= in_ctl;
            out_rem    <= rem_next;
            out_low    <= {in_low[QW-2:0], 1'b0};
            out_q      <= {in_q[QW-2:0], fits};
            out_len    <= in_len;
            out_sample <= in_sample;
        end
    end

    assign out_valid = valid_reg;

endmodule

FILE: hw/rtl/dahdsr_envelope_gain.sv
// channel | direction | words                          | handshake
// s_      | in        | frame_index, in_sample         | s_valid / s_ready
// m_      | out       | out_sample, finished           | m_valid / m_ready
// cfg_    | in        | cfg_addr, cfg_wdata            | cfg_we, no wait
//
// One word per cycle while the output is taken; stages: segment select, ramp
// product, 16 divider cells (one quotient bit each), gain multiply, saturate.
// Synchronous active-low reset empties the pipeline and restores the levels.
// The whole pipeline holds while the output word is not taken; s_ready is
// high whenever the output register is empty or being taken.
module dahdsr_envelope_gain import deg_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int LENGTH_WIDTH = 20
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [CFG_IDX_W-1:0]           cfg_addr,
    input  logic [((LENGTH_WIDTH > LEVEL_W) ? LENGTH_WIDTH : LEVEL_W)-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [31:0]                    s_frame_index,
    input  logic signed [SAMPLE_WIDTH-1:0] s_in_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_out_sample,
    output logic                           m_finished
);

    localparam int EW     = LENGTH_WIDTH + 3;          // sum of five lengths
    localparam int NUM_W  = LENGTH_WIDTH + QW;
    localparam int PROD_W = SAMPLE_WIDTH + LEVEL_W + 1;
    localparam int SH_W   = PROD_W - 15;

    // configuration
    logic [LENGTH_WIDTH-1:0] delay_reg, attack_reg, decay_reg, sustain_reg, release_reg;
    logic [LEVEL_W-1:0]      att_lvl_reg, sus_lvl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg   <= '0;
            attack_reg  <= '0;
            decay_reg   <= '0;
            sustain_reg <= '0;
            release_reg <= '0;
            att_lvl_reg <= LEVEL_ONE;
            sus_lvl_reg <= 16'd16384;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DELAY:   delay_reg   <= cfg_wdata[LENGTH_WIDTH-1:0];
                REG_ATTACK:  attack_reg  <= cfg_wdata[LENGTH_WIDTH-1:0];
                REG_DECAY:   decay_reg   <= cfg_wdata[LENGTH_WIDTH-1:0];
                REG_SUSTAIN: sustain_reg <= cfg_wdata[LENGTH_WIDTH-1:0];
                REG_RELEASE: release_reg <= cfg_wdata[LENGTH_WIDTH-1:0];
                REG_ATT_LVL: att_lvl_reg <= cfg_wdata[LEVEL_W-1:0];
                REG_SUS_LVL: sus_lvl_reg <= cfg_wdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // segment boundaries, cumulative
    logic [EW-1:0] e1, e2, e3, e4, e5;
    logic [LEVEL_W-1:0] al, sl;
    assign e1 = EW'(delay_reg);
    assign e2 = e1 + EW'(attack_reg);
    assign e3 = e2 + EW'(decay_reg);
    assign e4 = e3 + EW'(sustain_reg);
    assign e5 = e4 + EW'(release_reg);
    assign al = clamp_level(att_lvl_reg);
    assign sl = clamp_level(sus_lvl_reg);

    // stage 1: pick the segment; non-ramp segments divide 0 by 1
    logic [LENGTH_WIDTH-1:0] off_c, len_c;
    logic [LEVEL_W-1:0]      delta_c;
    deg_ctl_t                ctl_c;

    always_comb begin
        off_c   = '0;
        len_c   = LENGTH_WIDTH'(1);
        delta_c = '0;
        ctl_c   = '{base: '0, sub: 1'b0, past: 1'b0};
        if (s_frame_index < 32'(e1)) begin
            // silent delay
        end else if (s_frame_index < 32'(e2)) begin
            off_c   = LENGTH_WIDTH'(s_frame_index - 32'(e1));
            len_c   = attack_reg;
            delta_c = al;
        end else if (s_frame_index < 32'(e3)) begin
            off_c     = LENGTH_WIDTH'(s_frame_index - 32'(e2));
            len_c     = decay_reg;
            ctl_c.base = al;
            // truncation toward zero: work on the magnitude of the step
            if (al >= sl) begin
                delta_c   = al - sl;
                ctl_c.sub = 1'b1;
            end else begin
                delta_c   = sl - al;
            end
        end else if (s_frame_index < 32'(e4)) begin
            ctl_c.base = sl;
        end else if (s_frame_index < 32'(e5)) begin
            off_c      = LENGTH_WIDTH'(s_frame_index - 32'(e4));
            len_c      = release_reg;
            delta_c    = sl;
            ctl_c.base = sl;
            ctl_c.sub  = 1'b1;
        end else begin
            ctl_c.past = 1'b1;
        end
    end

    logic                           s1_valid_reg;
    deg_ctl_t                       s1_ctl_reg;
    logic [LENGTH_WIDTH-1:0]        s1_off_reg, s1_len_reg;
    logic [LEVEL_W-1:0]             s1_delta_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_sample_reg;

    // stage 2: ramp numerator
    logic                           s2_valid_reg;
    deg_ctl_t                       s2_ctl_reg;
    logic [NUM_W-1:0]               s2_num_reg;
    logic [LENGTH_WIDTH-1:0]        s2_len_reg;
    logic signed [SAMPLE_WIDTH-1:0] s2_sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ctl_reg    <= ctl_c;
            s1_off_reg    <= off_c;
            s1_len_reg    <= len_c;
            s1_delta_reg  <= delta_c;
            s1_sample_reg <= s_in_sample;
            s2_ctl_reg    <= s1_ctl_reg;
            s2_num_reg    <= NUM_W'(s1_off_reg) * NUM_W'(s1_delta_reg);
            s2_len_reg    <= s1_len_reg;
            s2_sample_reg <= s1_sample_reg;
        end
    end

    // divider chain; quotient < 2^QW so the top bits start below the divisor
    logic                           c_valid  [QW+1];
    deg_ctl_t                       c_ctl    [QW+1];
    logic [LENGTH_WIDTH-1:0]        c_rem    [QW+1];
    logic [QW-1:0]                  c_low    [QW+1];
    logic [QW-1:0]                  c_q      [QW+1];
    logic [LENGTH_WIDTH-1:0]        c_len    [QW+1];
    logic signed [SAMPLE_WIDTH-1:0] c_sample [QW+1];

    assign c_valid[0]  = s2_valid_reg;
    assign c_ctl[0]    = s2_ctl_reg;
    assign c_rem[0]    = s2_num_reg[NUM_W-1:QW];
    assign c_low[0]    = s2_num_reg[QW-1:0];
    assign c_q[0]      = '0;
    assign c_len[0]    = s2_len_reg;
    assign c_sample[0] = s2_sample_reg;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        deg_div_cell #(
            .LENGTH_WIDTH(LENGTH_WIDTH),
            .SAMPLE_WIDTH(SAMPLE_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (c_valid[k]),
            .in_ctl    (c_ctl[k]),
            .in_rem    (c_rem[k]),
            .in_low    (c_low[k]),
            .in_q      (c_q[k]),
            .in_len    (c_len[k]),
            .in_sample (c_sample[k]),
            .out_valid (c_valid[k+1]),
            .out_ctl   (c_ctl[k+1]),
            .out_rem   (c_rem[k+1]),
            .out_low   (c_low[k+1]),
            .out_q     (c_q[k+1]),
            .out_len   (c_len[k+1]),
            .out_sample(c_sample[k+1])
        );
    end

    // gain = base +/- quotient, then the sample product
    logic [LEVEL_W:0] gain_c;
    deg_ctl_t         ce;
    assign ce     = c_ctl[QW];
    assign gain_c = ce.sub ? ({1'b0, ce.base} - {1'b0, c_q[QW]})
                           : ({1'b0, ce.base} + {1'b0, c_q[QW]});

    logic                     mp_valid_reg, mp_past_reg;
    logic signed [PROD_W-1:0] mp_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mp_valid_reg <= 1'b0;
        end else if (en) begin
            mp_valid_reg <= c_valid[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mp_past_reg <= ce.past;
            mp_prod_reg <= PROD_W'(c_sample[QW]) * $signed({1'b0, gain_c});
        end
    end

    // floor shift by 15, then saturate
    logic signed [SH_W-1:0]         shifted;
    logic signed [SAMPLE_WIDTH-1:0] sat_c;
    localparam logic signed [SH_W-1:0] MAXV = SH_W'((64'sd1 <<< (SAMPLE_WIDTH-1)) - 1);
    localparam logic signed [SH_W-1:0] MINV = -SH_W'(64'sd1 <<< (SAMPLE_WIDTH-1));

    assign shifted = mp_prod_reg[PROD_W-1:15];

    always_comb begin
        if (mp_past_reg) begin
            sat_c = '0;
        end else if (shifted > MAXV) begin
            sat_c = MAXV[SAMPLE_WIDTH-1:0];
        end else if (shifted < MINV) begin
            sat_c = MINV[SAMPLE_WIDTH-1:0];
        end else begin
            sat_c = shifted[SAMPLE_WIDTH-1:0];
        end
    end

    logic out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= mp_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_out_sample <= sat_c;
            m_finished   <= mp_past_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

FILE: bench/tb_dahdsr_envelope_gain.sv
module tb_dahdsr_envelope_gain;
    timeunit 1ns;
    timeprecision 1ps;

    import deg_pkg::*;

    localparam int SW = 16;
    localparam int LW = 20;
    localparam int DW = 20;                     // widest register
    localparam int LIMIT_CYCLES = 600000;
    localparam int PIPE_WAIT = 40;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [31:0]          frame;
        logic signed [SW-1:0] smp;
    } word_in_t;

    typedef struct {
        logic signed [SW-1:0] smp;
        logic                 fin;
    } word_out_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [DW-1:0]        cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [31:0]          s_frame_index = '0;
    logic signed [SW-1:0] s_in_sample = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [SW-1:0] m_out_sample;
    logic                 m_finished;

    dahdsr_envelope_gain #(.SAMPLE_WIDTH(SW), .LENGTH_WIDTH(LW)) uut (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_valid, .s_ready, .s_frame_index, .s_in_sample,
        .m_valid, .m_ready, .m_out_sample, .m_finished
    );

    always #5 aclk = ~aclk;

    // bench copy of the envelope registers
    logic [LW-1:0] seg_len [5];
    logic [15:0]   att_lvl, sus_lvl;

    word_in_t   words_pending[$];
    word_out_t  gains_due[$];
    idle_mode_t idle_mode = IDLE_NONE;
    bit         send_hold = 1'b0;
    int         errors = 0;
    int         words_in = 0, words_out = 0, past_seen = 0;
    int         words_queued = 0;
    int         cycles = 0;

    // envelope gain (Q1.15) for one frame; past set beyond the envelope
    function automatic longint frame_gain(input logic [31:0] f, output bit past);
        longint al, sl, e, fi;
        al = (att_lvl > 16'd32768) ? 32768 : longint'(att_lvl);
        sl = (sus_lvl > 16'd32768) ? 32768 : longint'(sus_lvl);
        fi = longint'(f);
        e = longint'(seg_len[0]);
        past = 1'b0;
        if (fi < e) return 0;
        if (fi < e + seg_len[1]) return (fi - e) * al / longint'(seg_len[1]);
        e += seg_len[1];
        if (fi < e + seg_len[2]) return al - ((fi - e) * (al - sl)) / longint'(seg_len[2]);
        e += seg_len[2];
        if (fi < e + seg_len[3]) return sl;
        e += seg_len[3];
        if (fi < e + seg_len[4]) return sl - ((fi - e) * sl) / longint'(seg_len[4]);
        past = 1'b1;
        return 0;
    endfunction

    function automatic word_out_t gated_sample(input word_in_t w);
        word_out_t r;
        bit        past;
        longint    q;
        q = (longint'(w.smp) * frame_gain(w.frame, past)) >>> 15;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        if (past) q = 0;
        r.smp = q[SW-1:0];
        r.fin = past;
        return r;
    endfunction

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // words handed to the driver are counted here, so waits never race it
    function automatic void queue_word(input word_in_t w);
        words_pending.insert(words_pending.size(), w);
        words_queued++;
    endfunction

    // driver: one nonblocking update of s_valid per edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                gains_due.insert(gains_due.size(),
                                 gated_sample('{s_frame_index, s_in_sample}));
                words_in++;
            end
            if (!s_valid || s_ready) begin
                if (words_pending.size() > 0 && !send_hold &&
                    !((idle_mode == IDLE_SEND && roll(85)) ||
                      (idle_mode == IDLE_BOTH && roll(8)))) begin
                    word_in_t w;
                    w = words_pending.pop_front();
                    s_valid       <= 1'b1;
                    s_frame_index <= w.frame;
                    s_in_sample   <= w.smp;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: stall at random, check each taken word against the oldest due
    always @(posedge aclk) begin
        cycles++;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (gains_due.size() == 0) begin
                    $display("%0t: unexpected word out_sample=%0d finished=%0b",
                             $time, m_out_sample, m_finished);
                    errors++;
                end else begin
                    word_out_t x;
                    x = gains_due.pop_front();
                    if (x.smp !== m_out_sample) begin
                        $display("%0t: out_sample expected %0d actual %0d",
                                 $time, x.smp, m_out_sample);
                        errors++;
                    end
                    if (x.fin !== m_finished) begin
                        $display("%0t: finished expected %0b actual %0b",
                                 $time, x.fin, m_finished);
                        errors++;
                    end
                    words_out++;
                    if (x.fin) past_seen++;
                end
            end
            m_ready <= !((idle_mode == IDLE_RECV && roll(85)) ||
                         (idle_mode == IDLE_BOTH && roll(8)));
        end
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_DELAY, REG_ATTACK, REG_DECAY, REG_SUSTAIN, REG_RELEASE: begin
                seg_len[idx] = val[LW-1:0];
            end
            REG_ATT_LVL: att_lvl = val[15:0];
            REG_SUS_LVL: sus_lvl = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (words_out < words_queued)
            @(posedge aclk);
        repeat (PIPE_WAIT) @(posedge aclk);
    endtask

    function automatic logic [DW-1:0] rand_len();
        case ($urandom_range(9))
            0:       return '0;
            1:       return {LW{1'b1}};
            2:       return DW'($urandom);
            default: return DW'($urandom_range(40, 1));
        endcase
    endfunction

    function automatic logic [DW-1:0] rand_level();
        case ($urandom_range(5))
            0:       return '0;
            1:       return DW'(32768);
            2:       return DW'($urandom);          // upper bits dropped, may exceed one
            default: return DW'($urandom_range(32768));
        endcase
    endfunction

    function automatic logic [31:0] total_len();
        return 32'(seg_len[0]) + seg_len[1] + seg_len[2] + seg_len[3] + seg_len[4];
    endfunction

    initial begin
        logic [31:0] tot;
        logic [31:0] f;
        seg_len = '{default: '0};
        att_lvl = 16'd32768;
        sus_lvl = 16'd16384;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: all lengths zero, so every frame lies past the end
        queue_word('{32'd0, 16'sh7fff});
        queue_word('{32'hffff_ffff, -16'sd32768});
        drain();

        // directed: walk every segment and its edges with extreme samples
        write_reg(REG_DELAY, 20'd3);
        write_reg(REG_ATTACK, 20'd4);
        write_reg(REG_DECAY, 20'd5);
        write_reg(REG_SUSTAIN, 20'd2);
        write_reg(REG_RELEASE, 20'd6);
        write_reg(REG_ATT_LVL, 20'hf_ffff);         // above one, clamps
        write_reg(REG_SUS_LVL, 20'd10000);
        write_reg(REG_UNUSED, 20'h5_5555);          // ignored
        for (int i = 0; i < 22; i++)
            queue_word('{32'(i), (i % 3 == 0) ? -16'sd32768 :
                        (i % 3 == 1) ? 16'sd32767 : -16'sd1});
        drain();

        // random phases: new settings each time, idling cycles through the modes
        for (int ph = 0; ph < 14; ph++) begin
            for (int r = 0; r < 5; r++) write_reg(CFG_IDX_W'(r), rand_len());
            write_reg(REG_ATT_LVL, rand_level());
            write_reg(REG_SUS_LVL, rand_level());
            if (ph == 13) begin
                for (int r = 0; r < 5; r++) write_reg(CFG_IDX_W'(r), {LW{1'b1}});
            end
            idle_mode = idle_mode_t'(ph % 4);
            tot = total_len();
            for (int k = 0; k < 48; k++) begin
                // sender holds off once until everything owed is back
                if (ph == 5 && k == 24) begin
                    while (words_pending.size() > 0)
                        @(posedge aclk);
                    send_hold = 1'b1;
                    while (words_out < words_queued)
                        @(posedge aclk);
                    send_hold = 1'b0;
                end
                case ($urandom_range(9))
                    0, 1:    f = $urandom;
                    2:       f = tot + 32'($urandom_range(3)) - 32'd2;
                    default: f = $urandom_range(tot + 4);
                endcase
                queue_word('{f, SW'($urandom)});
            end
            drain();
        end

        $display("covered %0d words in, %0d out (%0d past the envelope), %0d settings",
                 words_in, words_out, past_seen, 16);
        $display("idling: none, sender 85%%, receiver 85%%, both 8%%; one full drain hold");
        if (errors == 0 && gains_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d errors, %0d words still owed", errors, gains_due.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/deg_pkg.sv
hw/rtl/deg_div_cell.sv
hw/rtl/dahdsr_envelope_gain.sv
bench/tb_dahdsr_envelope_gain.sv
